[hdl/pointer_bijection_checker_macros.svh]
// ----------------------------------------------------------------------------
// pointer bijection checker assertion macros
// shared concurrent assertion forms, clocked on clk with rst_n low as disable
// ----------------------------------------------------------------------------
`ifndef POINTER_BIJECTION_CHECKER_MACROS_SVH
`define POINTER_BIJECTION_CHECKER_MACROS_SVH

// condition that holds at every clock edge outside reset
`define PBC_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent in this cycle implies consequent in the following one
`define PBC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// antecedent implies consequent in the same cycle
`define PBC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

[hdl/pbc_pkg.sv]
// ----------------------------------------------------------------------------
// pbc_pkg
// shared types and constants of the pointer bijection checker
// ----------------------------------------------------------------------------
package pbc_pkg;

  localparam int PTR_W             = 64;
  localparam int TABLE_ENTRIES_DEF = 64;

  typedef enum logic [2:0] {
    OUT_MATCH    = 3'd0,
    OUT_MISMATCH = 3'd1,
    OUT_STORED   = 3'd2,
    OUT_MISUSE   = 3'd3,
    OUT_FULL     = 3'd4
  } outcome_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic [PTR_W-1:0] partner;
    logic             accepted;
    outcome_t         outcome;
  } result_t;

endpackage

[hdl/pbc_ram.sv]
// ----------------------------------------------------------------------------
// pbc_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module pbc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hdl/pbc_engine.sv]
// ----------------------------------------------------------------------------
// pbc_engine
// scans the pair table one entry a cycle and decides the outcome of one pair
// ----------------------------------------------------------------------------
`include "pointer_bijection_checker_macros.svh"

module pbc_engine #(
  parameter int TABLE_ENTRIES = pbc_pkg::TABLE_ENTRIES_DEF,
  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1,
  localparam int CW = $clog2(TABLE_ENTRIES + 1)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [pbc_pkg::PTR_W-1:0] in_rec,
  input  logic [pbc_pkg::PTR_W-1:0] in_rep,
  output logic                    res_valid,
  input  logic                    res_ready,
  output pbc_pkg::result_t        res,
  output logic                    mem_we,
  output logic [AW-1:0]           mem_waddr,
  output logic [AW-1:0]           mem_raddr,
  input  logic [pbc_pkg::PTR_W-1:0] mem_rrec,
  input  logic [pbc_pkg::PTR_W-1:0] mem_rrep
);

  pbc_pkg::state_t state_r, state_nxt;

  logic [pbc_pkg::PTR_W-1:0] rec_r, rep_r;
  logic [CW-1:0]             idx_r, idx_nxt;
  logic [CW-1:0]             used_r, used_nxt;
  logic                      cmp_vld_r, cmp_vld_nxt;
  logic                      mis_r, mis_nxt;
  logic [pbc_pkg::PTR_W-1:0] mis_partner_r, mis_partner_nxt;
  pbc_pkg::result_t          res_r, res_nxt;

  logic issue, rec_hit, rep_hit, finish, accept, table_full;

  assign accept     = in_valid && in_ready;
  assign rec_hit    = cmp_vld_r && (mem_rrec == rec_r);
  assign rep_hit    = cmp_vld_r && (mem_rrep == rep_r);
  assign table_full = (used_r == CW'(TABLE_ENTRIES));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pbc_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = pbc_pkg::ST_SCAN;
        end
      end
      pbc_pkg::ST_SCAN: begin
        if (finish) begin
          state_nxt = pbc_pkg::ST_RESULT;
        end
      end
      pbc_pkg::ST_RESULT: begin
        if (res_ready) begin
          state_nxt = pbc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pbc_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready  = 1'b0;
    res_valid = 1'b0;
    issue     = 1'b0;
    finish    = 1'b0;
    case (state_r)
      pbc_pkg::ST_IDLE:   in_ready = 1'b1;
      pbc_pkg::ST_SCAN: begin
        issue  = (idx_r < used_r);
        finish = rec_hit || !issue;
      end
      pbc_pkg::ST_RESULT: res_valid = 1'b1;
      default: ;
    endcase
  end

  // scan datapath and outcome decision
  always_comb begin
    idx_nxt         = idx_r;
    used_nxt        = used_r;
    cmp_vld_nxt     = issue && !finish;
    mis_nxt         = mis_r;
    mis_partner_nxt = mis_partner_r;
    res_nxt         = res_r;
    mem_we          = 1'b0;

    if (accept) begin
      idx_nxt = '0;
      mis_nxt = 1'b0;
    end
    if (issue) begin
      idx_nxt = idx_r + CW'(1);
    end
    if (rep_hit) begin
      mis_nxt         = 1'b1;
      mis_partner_nxt = mem_rrec;
    end

    if (finish) begin
      res_nxt.partner  = '0;
      res_nxt.accepted = 1'b0;
      if (rec_hit) begin
        if (mem_rrep == rep_r) begin
          res_nxt.outcome  = pbc_pkg::OUT_MATCH;
          res_nxt.accepted = 1'b1;
        end else begin
          res_nxt.outcome = pbc_pkg::OUT_MISMATCH;
          res_nxt.partner = mem_rrep;
        end
      end else if (rep_hit || mis_r) begin
        res_nxt.outcome = pbc_pkg::OUT_MISUSE;
        res_nxt.partner = rep_hit ? mem_rrec : mis_partner_r;
      end else if (table_full) begin
        res_nxt.outcome = pbc_pkg::OUT_FULL;
      end else begin
        res_nxt.outcome  = pbc_pkg::OUT_STORED;
        res_nxt.accepted = 1'b1;
        mem_we           = 1'b1;
        used_nxt         = used_r + CW'(1);
      end
    end
  end

  assign mem_raddr = idx_r[AW-1:0];
  assign mem_waddr = used_r[AW-1:0];
  assign res       = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= pbc_pkg::ST_IDLE;
      used_r    <= '0;
      cmp_vld_r <= 1'b0;
      idx_r     <= '0;
      mis_r     <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      used_r    <= used_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      idx_r     <= idx_nxt;
      mis_r     <= mis_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rec_r <= in_rec;
      rep_r <= in_rep;
    end
    mis_partner_r <= mis_partner_nxt;
    res_r         <= res_nxt;
  end

  `PBC_ASSERT_ALWAYS(a_used_bound, used_r <= CW'(TABLE_ENTRIES), "fill count beyond table size")
  `PBC_ASSERT_NEXT(a_store_counts, mem_we, used_r == $past(used_r) + CW'(1), "store did not advance fill count")
  `PBC_ASSERT_IMPL(a_cmp_in_scan, cmp_vld_r, state_r == pbc_pkg::ST_SCAN, "read data pending outside scan")
  `PBC_ASSERT_IMPL(a_idx_bound, state_r == pbc_pkg::ST_SCAN, idx_r <= used_r, "scan index past filled entries")

endmodule

[hdl/pointer_bijection_checker.sv]
// ----------------------------------------------------------------------------
// pointer_bijection_checker
// one-to-one table of recorded and replayed pointer pairs with match check
// ----------------------------------------------------------------------------
//
//   channel | dir | tdata                      | tuser
//   --------+-----+----------------------------+-------------------------------
//   in_     | in  | recorded_addr, replayed    | -
//   out_    | out | bound_partner              | outcome, accepted
//
// an item is scanned and handed to the output register before the next input
// transfer: the table is scanned through one read port of the two rams, one
// entry per cycle, and a recorded pointer hit ends the scan early
// reset clears only the fill count and control; table rams have no clear
// the input side stalls while a pair is being scanned; a finished result in
// the output register does not hold back the next input transfer
// ----------------------------------------------------------------------------
`include "pointer_bijection_checker_macros.svh"

module pointer_bijection_checker #(
  parameter int TABLE_ENTRIES = pbc_pkg::TABLE_ENTRIES_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  // input pair channel
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // [63:0] recorded_addr, [127:64] replayed_addr
  // result channel
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [63:0]  out_tdata,  // [63:0] bound_partner
  output logic [3:0]   out_tuser   // [2:0] outcome, [3] accepted
);

  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  // table ram interface
  logic                      mem_we;
  logic [AW-1:0]             mem_waddr;
  logic [AW-1:0]             mem_raddr;
  logic [pbc_pkg::PTR_W-1:0] mem_rrec;
  logic [pbc_pkg::PTR_W-1:0] mem_rrep;
  logic [pbc_pkg::PTR_W-1:0] rec_r_unused;

  // engine to output register handoff
  logic             res_valid;
  logic             res_ready;
  pbc_pkg::result_t res;

  // output register
  logic             out_vld_r, out_vld_nxt;
  pbc_pkg::result_t out_res_r;

  // engine latches the pair on its own transfer; write data come from a copy registered here
  logic [pbc_pkg::PTR_W-1:0] wrec, wrep;

  pbc_engine #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_rec    (in_tdata[63:0]),
    .in_rep    (in_tdata[127:64]),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_raddr (mem_raddr),
    .mem_rrec  (mem_rrec),
    .mem_rrep  (mem_rrep)
  );

  // write data registered on input transfer, stable for the whole scan
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      wrec <= in_tdata[63:0];
      wrep <= in_tdata[127:64];
    end
  end

  assign rec_r_unused = wrec;

  // recorded pointer column
  pbc_ram #(
    .WIDTH (pbc_pkg::PTR_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram_rec (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (rec_r_unused),
    .raddr (mem_raddr),
    .rdata (mem_rrec)
  );

  // replayed pointer column
  pbc_ram #(
    .WIDTH (pbc_pkg::PTR_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram_rep (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (wrep),
    .raddr (mem_raddr),
    .rdata (mem_rrep)
  );

  // output register takes a new result when empty or being drained
  assign res_ready = !out_vld_r || out_tready;

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid     = out_vld_r;
  assign out_tdata      = out_res_r.partner;
  assign out_tuser[2:0] = out_res_r.outcome;
  assign out_tuser[3]   = out_res_r.accepted;

  `PBC_ASSERT_IMPL(a_accepted_code, out_tvalid, out_tuser[3] == (out_tuser[2:0] == pbc_pkg::OUT_MATCH || out_tuser[2:0] == pbc_pkg::OUT_STORED), "accepted flag disagrees with outcome")
  `PBC_ASSERT_IMPL(a_partner_zero, out_tvalid && out_tuser[2:0] != pbc_pkg::OUT_MISMATCH && out_tuser[2:0] != pbc_pkg::OUT_MISUSE, out_tdata == '0, "partner set for outcome without one")
  `PBC_ASSERT_NEXT(a_one_in_flight, in_tvalid && in_tready, !in_tready, "second pair taken during scan")

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// drives pointer pairs into pointer_bijection_checker and checks every verdict
// against a local copy of the pair table, with random idling on both streams
// ----------------------------------------------------------------------------
module tb;
  import pbc_pkg::*;

  localparam int DEPTH        = TABLE_ENTRIES_DEF;
  localparam int RANDOM_PAIRS = 1000;
  localparam int CYCLE_LIMIT  = 1_000_000;

  // local copy of the pair table and the verdicts still owed by the block
  class bijection_scoreboard;
    logic [63:0] rec_col[DEPTH];
    logic [63:0] rep_col[DEPTH];
    int unsigned fill;
    result_t     pending_verdicts[$];
    int unsigned failures;
    int unsigned checked;
    int unsigned tally[5];

    function new();
      fill     = 0;
      failures = 0;
      checked  = 0;
      foreach (tally[k]) tally[k] = 0;
    endfunction

    // recorded lookup first, then replayed lookup, then room for a new entry
    function void note_pair(logic [63:0] rec, logic [63:0] rep);
      result_t v;
      int      hit;
      v.partner  = '0;
      v.accepted = 1'b0;
      v.outcome  = OUT_FULL;
      hit = -1;
      for (int i = 0; i < fill; i++) begin
        if (hit < 0 && rec_col[i] == rec) hit = i;
      end
      if (hit >= 0) begin
        if (rep_col[hit] == rep) begin
          v.outcome = OUT_MATCH;
        end else begin
          v.outcome = OUT_MISMATCH;
          v.partner = rep_col[hit];
        end
      end else begin
        for (int i = 0; i < fill; i++) begin
          if (hit < 0 && rep_col[i] == rep) hit = i;
        end
        if (hit >= 0) begin
          v.outcome = OUT_MISUSE;
          v.partner = rec_col[hit];
        end else if (fill >= DEPTH) begin
          v.outcome = OUT_FULL;
        end else begin
          rec_col[fill] = rec;
          rep_col[fill] = rep;
          fill++;
          v.outcome = OUT_STORED;
        end
      end
      v.accepted = (v.outcome == OUT_MATCH || v.outcome == OUT_STORED);
      pending_verdicts.push_back(v);
    endfunction

    function void check_verdict(logic [63:0] data, logic [3:0] user);
      result_t want;
      if (pending_verdicts.size() == 0) begin
        $error("result with nothing pending: outcome %0d accepted %0d partner %h",
               user[2:0], user[3], data);
        failures++;
        return;
      end
      want = pending_verdicts.pop_front();
      checked++;
      tally[int'(want.outcome)]++;
      if (user[2:0] !== want.outcome) begin
        $error("outcome: expected %0d, got %0d", want.outcome, user[2:0]);
        failures++;
      end
      if (user[3] !== want.accepted) begin
        $error("accepted: expected %0d, got %0d", want.accepted, user[3]);
        failures++;
      end
      if (data !== want.partner) begin
        $error("bound_partner: expected %h, got %h", want.partner, data);
        failures++;
      end
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;   // [63:0] recorded_addr, [127:64] replayed_addr
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [63:0]  out_tdata;       // [63:0] bound_partner
  logic [3:0]   out_tuser;       // [2:0] outcome, [3] accepted

  bijection_scoreboard book = new();
  bit          no_idle = 1'b0;   // both sides run flat out while set
  int unsigned sent = 0;
  int unsigned cycles = 0;
  int          stall_left = 0;

  pointer_bijection_checker #(
    .TABLE_ENTRIES(DEPTH)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit, sized far above the slowest legal run
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // result side: check each transfer, then pick ready for the next cycle
  // mostly ready, short stalls now and then, a rare long one
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) book.check_verdict(out_tdata, out_tuser);
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left = stall_left - 1;
    end else if (no_idle || $urandom_range(0, 99) < 65) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= 1'b0;
      stall_left = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 2)
                                                 : $urandom_range(10, 40);
    end
  end

  // sender gap after a transfer: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // pointer value with a bias toward the corners of the 64-bit range
  function automatic logic [63:0] rand_ptr();
    logic [63:0] one_hot;
    one_hot = 64'd1 << $urandom_range(0, 63);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return one_hot;
      3:       return ~one_hot;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // one pair transfer; valid stays high when no gap follows
  task automatic send_pair(input logic [63:0] rec, input logic [63:0] rep);
    int gap;
    in_tdata  <= {rep, rec};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    book.note_pair(rec, rep);
    sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (book.pending_verdicts.size() != 0) @(posedge clk);
  endtask

  // mostly pairs built from the current table so that every outcome shows up,
  // new pairs often enough that the table fills part way through the run
  task automatic pick_pair(output logic [63:0] rec, output logic [63:0] rep);
    int          r;
    int unsigned i;
    int unsigned j;
    logic [63:0] flip;
    r    = $urandom_range(0, 99);
    i    = (book.fill > 0) ? $urandom_range(0, book.fill - 1) : 0;
    j    = (book.fill > 0) ? $urandom_range(0, book.fill - 1) : 0;
    flip = 64'd1 << $urandom_range(0, 63);
    if (book.fill == 0) r = 85;
    if (r < 30) begin
      // replay of a known pair
      rec = book.rec_col[i];
      rep = book.rep_col[i];
    end else if (r < 55) begin
      // known recorded pointer, other replayed pointer
      rec = book.rec_col[i];
      case ($urandom_range(0, 2))
        0:       rep = book.rep_col[i] ^ flip;
        1:       rep = book.rep_col[j];
        default: rep = rand_ptr();
      endcase
    end else if (r < 80) begin
      // replayed pointer already bound to some other recorded pointer
      rep = book.rep_col[i];
      rec = $urandom_range(0, 1) ? (book.rec_col[i] ^ flip) : rand_ptr();
    end else if (r < 92) begin
      rec = {$urandom, $urandom};
      rep = {$urandom, $urandom};
    end else begin
      rec = rand_ptr();
      rep = rand_ptr();
    end
  endtask

  initial begin : stimulus
    logic [63:0] rec;
    logic [63:0] rep;
    logic [63:0] pa;
    logic [63:0] pb;

    rst_n <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: corner pointers and each outcome but a full table
    pa = {$urandom, $urandom};
    pb = {$urandom, $urandom};
    send_pair('0, '1);                        // stored
    send_pair('1, '0);                        // stored
    send_pair('0, '1);                        // match
    send_pair('0, '0);                        // mismatch, partner all ones
    send_pair('1, '1);                        // mismatch, partner zero
    send_pair(64'd5, '1);                     // all ones already bound to zero
    send_pair(pa, pb);                        // stored
    send_pair(pa, pb);                        // match
    send_pair(pa, pb ^ 64'h8000_0000_0000_0000);
    send_pair(pa ^ 64'd1, pb);                // misuse
    send_pair({32{2'b10}}, {32{2'b01}});      // stored
    send_pair({32{2'b01}}, {32{2'b10}});      // stored
    send_pair({32{2'b10}}, {32{2'b10}});      // mismatch
    no_idle = 1'b1;
    send_pair(pa, pb);                        // back to back
    send_pair('1, '0);
    send_pair(64'd5, pb);
    no_idle = 1'b0;

    // random part, with one full drain at the midpoint
    for (int n = 0; n < RANDOM_PAIRS; n++) begin
      no_idle = (n % 250) >= 200;
      if (n == RANDOM_PAIRS / 2) begin
        drain_results();
        repeat ($urandom_range(5, 20)) @(posedge clk);
      end
      pick_pair(rec, rep);
      send_pair(rec, rep);
    end
    no_idle = 1'b0;

    // make sure the table is full, then hit every lookup on a full table
    while (book.fill < DEPTH) send_pair({$urandom, $urandom}, {$urandom, $urandom});
    send_pair({$urandom, $urandom}, {$urandom, $urandom});         // no room
    send_pair(book.rec_col[DEPTH-1], book.rep_col[DEPTH-1]);       // match
    send_pair(book.rec_col[0], book.rep_col[0] ^ 64'd1);           // mismatch
    send_pair(book.rec_col[DEPTH/2] ^ 64'd2, book.rep_col[DEPTH/2]); // misuse

    drain_results();
    repeat (DEPTH + 8) @(posedge clk);

    $display("summary: %0d pairs sent, %0d verdicts checked, table %0d of %0d entries",
             sent, book.checked, book.fill, DEPTH);
    $display("summary: match %0d, mismatch %0d, stored %0d, misuse %0d, full %0d",
             book.tally[0], book.tally[1], book.tally[2], book.tally[3], book.tally[4]);
    if (book.failures == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hdl
hdl/pbc_pkg.sv
hdl/pbc_ram.sv
hdl/pbc_engine.sv
hdl/pointer_bijection_checker.sv
tb/tb.sv
